// ===== hdl/fcam_pkg.sv =====
package fcam_pkg;

   typedef enum logic [1:0] {
      OP_ENCODE = 2'd0,
      OP_DECODE = 2'd1,
      OP_ADD    = 2'd2,
      OP_MUL    = 2'd3
   } opcode_type;

   localparam logic [31:0] QNAN_WORD       = 32'h7FC0_0000;
   localparam logic [6:0]  FP8_MAG_MAX     = 7'h7F;
   localparam logic [1:0]  CSR_FORMAT_ADDR = 2'd0;
   localparam logic [4:0]  ALIGN_MAX       = 5'd27;

   typedef struct packed {
      logic              sign;
      logic              nan;
      logic              zero;
      logic signed [6:0] exp;
      logic [3:0]        sig;
   } fp8_dec_type;

   function automatic fp8_dec_type fp8_unpack(logic [7:0] code, logic fmt);
      fp8_dec_type d;
      d.sign = code[7];
      d.nan  = (code[6:0] == FP8_MAG_MAX);
      d.zero = (code == 8'h00);
      if (fmt) begin
         d.sig = {1'b1, code[1:0], 1'b0};
         d.exp = $signed({2'b00, code[6:2]}) - 7'sd15;
      end else begin
         d.sig = {1'b1, code[2:0]};
         d.exp = $signed({3'b000, code[6:3]}) - 7'sd7;
      end
      if (d.zero) begin
         d.sig = 4'd0;
      end
      return d;
   endfunction

   function automatic logic [31:0] fp8_to_word(logic [7:0] code, logic fmt);
      logic [31:0] w;
      if (code[6:0] == FP8_MAG_MAX) begin
         w = QNAN_WORD;
      end else if (code == 8'h00) begin
         w = 32'd0;
      end else if (fmt) begin
         w = {code[7], {3'b000, code[6:2]} + 8'd112, code[1:0], 21'd0};
      end else begin
         w = {code[7], {4'b0000, code[6:3]} + 8'd120, code[2:0], 20'd0};
      end
      return w;
   endfunction

   function automatic logic [7:0] word_to_fp8(logic [31:0] w, logic fmt);
      logic              s;
      logic [7:0]        fe;
      logic [22:0]       fr;
      logic signed [9:0] be0;
      logic signed [9:0] be1;
      logic signed [9:0] emax;
      logic [3:0]        q;
      logic [7:0]        r;
      s  = w[31];
      fe = w[30:23];
      fr = w[22:0];
      if (fmt) begin
         q    = {2'b00, fr[22:21]} + {3'b000, fr[20]};
         be0  = $signed({2'b00, fe}) - 10'sd112;
         emax = 10'sd31;
      end else begin
         q    = {1'b0, fr[22:20]} + {3'b000, fr[19]};
         be0  = $signed({2'b00, fe}) - 10'sd120;
         emax = 10'sd15;
      end
      be1 = be0;
      if ((fmt && q == 4'd4) || (!fmt && q == 4'd8)) begin
         q   = 4'd0;
         be1 = be0 + 10'sd1;
      end
      if (fe == 8'hFF) begin
         r = (fr != 23'd0) ? {1'b0, FP8_MAG_MAX} : {s, FP8_MAG_MAX};
      end else if (fe == 8'h00 || be0 < 10'sd0) begin
         r = 8'h00;
      end else if (be1 > emax) begin
         r = {s, FP8_MAG_MAX};
      end else if (fmt) begin
         r = {s, be1[4:0], q[1:0]};
      end else begin
         r = {s, be1[3:0], q[2:0]};
      end
      return r;
   endfunction

   function automatic logic [4:0] lead_pos(logic [31:0] x);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

   typedef struct packed {
      opcode_type        op;
      logic              fmt;
      logic [31:0]       pass;
      logic              nan;
      logic              sign_a;
      logic              sign_b;
      logic [3:0]        sig_a;
      logic [3:0]        sig_b;
      logic signed [6:0] exp_a;
      logic signed [6:0] exp_b;
      logic              eff_sub;
      logic              big_sign;
      logic [3:0]        big_sig;
      logic [3:0]        small_sig;
      logic signed [6:0] big_exp;
      logic [4:0]        shift;
   } s1_type;

   typedef struct packed {
      opcode_type        op;
      logic              fmt;
      logic [31:0]       pass;
      logic              nan;
      logic              sign;
      logic [31:0]       x;
      logic signed [7:0] base;
   } s2_type;

   typedef struct packed {
      logic        encode;
      logic        fmt;
      logic [31:0] word;
   } s3_type;

endpackage

// ===== hdl/fp8_convert_add_multiply_unit.sv =====
// Pipeline: an accepted item passes through s1_ff, s2_ff, s3_ff and out_ff;
// out_ff drives rsp_result_word while rsp_valid is high; four register stages.
// Throughput: one item per cycle; a stall holds each stage only while the
// stage after it is full, so bubbles close up.
// Reset: synchronous, active high; clears all stage valid bits and sets the
// format register to E4M3.
module fp8_convert_add_multiply_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_operand_a,
   input  logic [7:0]  req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_word,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fcam_pkg::*;

   logic        fmt_ff;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        r1, r2, r3, r4;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   logic [31:0] out_ff, out_in;

   fp8_dec_type       da, db;
   logic              a_big;
   fp8_dec_type       big, small_op;
   logic signed [6:0] ediff;

   logic [31:0] big_sh;

   logic [4:0]        p;
   logic [31:0]       y;
   logic              rnd;
   logic [23:0]       mant_r;
   logic signed [9:0] expf;
   logic [31:0]       arith_word;

   assign pready = 1'b1;
   assign prdata = {31'd0, fmt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr == CSR_FORMAT_ADDR) begin
         fmt_ff <= pwdata[0];
      end
   end

   assign r4        = !v4_ff || rsp_ready;
   assign r3        = !v3_ff || r4;
   assign r2        = !v2_ff || r3;
   assign r1        = !v1_ff || r2;
   assign req_ready = r1;
   assign rsp_valid = v4_ff;
   assign rsp_result_word = out_ff;

   // decode and order operands
   always_comb begin
      da    = fp8_unpack(req_operand_a[7:0], fmt_ff);
      db    = fp8_unpack(req_operand_b, fmt_ff);
      a_big = {req_operand_a[6:0], !da.zero} >= {req_operand_b[6:0], !db.zero};
      big      = a_big ? da : db;
      small_op = a_big ? db : da;
      ediff    = big.exp - small_op.exp;
      s1_in.op        = opcode_type'(req_opcode);
      s1_in.fmt       = fmt_ff;
      s1_in.pass      = (opcode_type'(req_opcode) == OP_ENCODE) ? req_operand_a
                        : fp8_to_word(req_operand_a[7:0], fmt_ff);
      s1_in.nan       = da.nan || db.nan;
      s1_in.sign_a    = da.sign;
      s1_in.sign_b    = db.sign;
      s1_in.sig_a     = da.sig;
      s1_in.sig_b     = db.sig;
      s1_in.exp_a     = da.exp;
      s1_in.exp_b     = db.exp;
      s1_in.eff_sub   = da.sign ^ db.sign;
      s1_in.big_sign  = big.sign;
      s1_in.big_sig   = big.sig;
      s1_in.small_sig = small_op.sig;
      s1_in.big_exp   = big.exp;
      s1_in.shift     = (ediff > $signed({2'b00, ALIGN_MAX})) ? ALIGN_MAX : ediff[4:0];
   end

   // align and add, or multiply
   always_comb begin
      big_sh      = {28'd0, s1_ff.big_sig} << s1_ff.shift;
      s2_in.op    = s1_ff.op;
      s2_in.fmt   = s1_ff.fmt;
      s2_in.pass  = s1_ff.pass;
      s2_in.nan   = s1_ff.nan;
      if (s1_ff.op == OP_MUL) begin
         s2_in.sign = s1_ff.sign_a ^ s1_ff.sign_b;
         s2_in.x    = {24'd0, {4'd0, s1_ff.sig_a} * {4'd0, s1_ff.sig_b}};
         s2_in.base = 8'(s1_ff.exp_a) + 8'(s1_ff.exp_b) - 8'sd6;
      end else begin
         s2_in.sign = s1_ff.big_sign;
         s2_in.x    = s1_ff.eff_sub ? big_sh - {28'd0, s1_ff.small_sig}
                                    : big_sh + {28'd0, s1_ff.small_sig};
         s2_in.base = 8'(s1_ff.big_exp) - 8'sd3 - $signed({3'b000, s1_ff.shift});
      end
   end

   // normalise and round to float32
   always_comb begin
      p      = lead_pos(s2_ff.x);
      y      = s2_ff.x << (~p);
      rnd    = y[7] && ((|y[6:0]) || y[8]);
      mant_r = {1'b0, y[30:8]} + {23'd0, rnd};
      expf   = $signed({5'd0, p}) + 10'(s2_ff.base) + 10'sd127
               + $signed({9'd0, mant_r[23]});
      if (s2_ff.nan) begin
         arith_word = QNAN_WORD;
      end else if (s2_ff.x == 32'd0) begin
         arith_word = 32'd0;
      end else begin
         arith_word = {s2_ff.sign, expf[7:0], mant_r[22:0]};
      end
      s3_in.encode = (s2_ff.op != OP_DECODE);
      s3_in.fmt    = s2_ff.fmt;
      s3_in.word   = (s2_ff.op == OP_ADD || s2_ff.op == OP_MUL) ? arith_word
                                                                : s2_ff.pass;
   end

   assign out_in = s3_ff.encode ? {24'd0, word_to_fp8(s3_ff.word, s3_ff.fmt)}
                                : s3_ff.word;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= req_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
         if (r4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && req_valid) begin
         s1_ff <= s1_in;
      end
      if (r2 && v1_ff) begin
         s2_ff <= s2_in;
      end
      if (r3 && v2_ff) begin
         s3_ff <= s3_in;
      end
      if (r4 && v3_ff) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== tb/tb_fp8_convert_add_multiply_unit.sv =====
module tb_fp8_convert_add_multiply_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import fcam_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_operand_a = '0;
   logic [7:0]  req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_word;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic        format_sel = 1'b0;
   logic        quiet_mode = 1'b0;
   int          hold_seq = 0;
   int          hold_seen = 0;
   int          hold_cnt = 0;
   int          cycle_cnt = 0;
   int          errors = 0;
   logic [31:0] expected_words[$];

   fp8_convert_add_multiply_unit dut (.*);

   always #5 clock = ~clock;

   function automatic logic [7:0] pred_encode(logic [31:0] w, logic f);
      int          mb;
      int          bias;
      int          emax;
      logic        sgn;
      int          fe;
      logic [22:0] fr;
      int          be;
      int          q;
      mb   = f ? 2 : 3;
      bias = f ? 15 : 7;
      emax = f ? 31 : 15;
      sgn  = w[31];
      fe   = w[30:23];
      fr   = w[22:0];
      if (fe == 255) return (fr != 0) ? 8'h7F : {sgn, 7'h7F};
      if (fe == 0) return 8'h00;
      be = fe - 127 + bias;
      if (be < 0) return 8'h00;
      q = fr >> (23 - mb);
      q += (fr >> (22 - mb)) & 1;
      if (q == (1 << mb)) begin
         q = 0;
         be++;
      end
      if (be > emax) return {sgn, 7'h7F};
      return {sgn, 7'((be << mb) | q)};
   endfunction

   function automatic logic [31:0] pred_decode(logic [7:0] code, logic f);
      int mb;
      int bias;
      mb   = f ? 2 : 3;
      bias = f ? 15 : 7;
      if (code[6:0] == 7'h7F) return 32'h7FC0_0000;
      if (code == 8'h00) return 32'h0;
      return {code[7], 8'((code[6:0] >> mb) - bias + 127),
              23'((code & ((1 << mb) - 1)) << (23 - mb))};
   endfunction

   function automatic real fp8_to_real(logic [7:0] code, logic f);
      int mb;
      int bias;
      mb   = f ? 2 : 3;
      bias = f ? 15 : 7;
      if (code == 8'h00) return 0.0;
      return $bitstoreal({code[7], 11'((code[6:0] >> mb) - bias + 1023),
                          52'(64'(code & ((1 << mb) - 1)) << (52 - mb))});
   endfunction

   function automatic logic [31:0] real_to_float(real r);
      logic [63:0] d;
      logic [30:0] mag;
      logic        rnd;
      d = $realtobits(r);
      if (d[62:0] == 0) return {d[63], 31'd0};
      rnd = d[28] && ((|d[27:0]) || d[29]);
      mag = {8'(d[62:52] - 1023 + 127), d[51:29]};
      return {d[63], mag + 31'(rnd)};
   endfunction

   function automatic logic [31:0] predict_word(opcode_type op, logic [31:0] a,
                                               logic [7:0] b, logic f);
      real x;
      real y;
      case (op)
         OP_ENCODE: return {24'd0, pred_encode(a, f)};
         OP_DECODE: return pred_decode(a[7:0], f);
         default: begin
            if (a[6:0] == 7'h7F || b[6:0] == 7'h7F) return 32'h7F;
            x = fp8_to_real(a[7:0], f);
            y = fp8_to_real(b, f);
            return {24'd0, pred_encode(real_to_float(op == OP_ADD ? x + y : x * y), f)};
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, want %h", what, got, want);
      errors++;
   endtask

   task automatic send_item(opcode_type op, logic [31:0] a, logic [7:0] b);
      if (!quiet_mode && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(predict_word(op, a, b, format_sel));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_format(logic f);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_FORMAT_ADDR;
      pwdata  <= {31'($urandom), f};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      format_sel = f;
      @(posedge clock);
      psel  <= 1'b1;
      paddr <= CSR_FORMAT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== f) report_mismatch("format readback", prdata, {31'd0, f});
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed;
      send_item(OP_ENCODE, 32'h0000_0000, 8'hFF);
      send_item(OP_ENCODE, 32'h8000_0000, 8'h00);
      send_item(OP_ENCODE, 32'h7F80_0000, 8'h00);
      send_item(OP_ENCODE, 32'hFF80_0000, 8'h00);
      send_item(OP_ENCODE, 32'hFFC0_0001, 8'h00);
      send_item(OP_ENCODE, 32'h0000_0001, 8'h00);
      send_item(OP_ENCODE, 32'h3F80_0000, 8'h00);
      send_item(OP_ENCODE, 32'hBF88_0000, 8'h00);
      send_item(OP_ENCODE, 32'h3FF8_0000, 8'h00);
      send_item(OP_ENCODE, 32'h3A00_0000, 8'h00);
      send_item(OP_ENCODE, 32'h4780_0000, 8'h00);
      send_item(OP_ENCODE, 32'hC37F_FFFF, 8'h00);
      send_item(OP_DECODE, 32'hFFFF_FF00, 8'hFF);
      send_item(OP_DECODE, 32'h0000_007F, 8'h00);
      send_item(OP_DECODE, 32'hABCD_EFFF, 8'h00);
      send_item(OP_DECODE, 32'h0000_0080, 8'h00);
      send_item(OP_DECODE, 32'h0000_0001, 8'h00);
      send_item(OP_DECODE, 32'h0000_00FE, 8'h00);
      send_item(OP_ADD, 32'h0000_007F, 8'h38);
      send_item(OP_ADD, 32'h0000_0038, 8'hB8);
      send_item(OP_ADD, 32'hFFFF_FF7E, 8'h01);
      send_item(OP_MUL, 32'h0000_007E, 8'h7E);
      send_item(OP_MUL, 32'h0000_0000, 8'hBA);
      send_item(OP_MUL, 32'h0000_0001, 8'h81);
      drain();
   endtask

   function automatic logic [7:0] pick_code();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'h7F;
         2: return 8'hFF;
         3: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_random(int count);
      logic [31:0] a;
      opcode_type  op;
      for (int i = 0; i < count; i++) begin
         op = opcode_type'($urandom_range(3));
         if (op == OP_ENCODE) begin
            case ($urandom_range(9))
               0, 1: a = $urandom;
               2: a = {1'($urandom), ($urandom_range(1) ? 8'hFF : 8'h00),
                       ($urandom_range(1) ? 23'($urandom) : 23'd0)};
               3, 4: a = {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)}
                         & (format_sel ? 32'hFFE0_0000 : 32'hFFF0_0000)
                         | (format_sel ? 32'h0010_0000 : 32'h0008_0000);
               default: a = {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
            endcase
         end else begin
            a = {24'($urandom), pick_code()};
         end
         send_item(op, a, pick_code());
      end
      drain();
   endtask

   task automatic test_backpressure;
      hold_seq++;
      quiet_mode = 1'b1;
      test_random(150);
      quiet_mode = 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_cnt  <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_mode || ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected item", rsp_result_word, 32'h0);
         end else begin
            if (rsp_result_word !== expected_words[0])
               report_mismatch("result_word", rsp_result_word, expected_words[0]);
            void'(expected_words.pop_front());
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200);
      write_format(1'b1);
      test_directed();
      test_random(200);
      quiet_mode = 1'b1;
      test_random(150);
      quiet_mode = 1'b0;
      test_backpressure();
      write_format(1'b0);
      test_random(200);
      test_backpressure();
      write_format(1'b1);
      test_random(150);
      drain();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
